// ===== hw/rtl/rau_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the micro-program for the rational arithmetic unit.
// Used by rau_iter, rau_dp, rau_ctrl and the top level; depends on nothing.
package rau_pkg;

    localparam int WORD_BITS = 64;
    localparam int PC_BITS   = 5;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [PC_BITS-1:0] LAST_PC = 5'd28;

    localparam logic [2:0] KIND_NORM = 3'd0;
    localparam logic [2:0] KIND_ADD  = 3'd1;
    localparam logic [2:0] KIND_SUB  = 3'd2;
    localparam logic [2:0] KIND_MUL  = 3'd3;
    localparam logic [2:0] KIND_DIV  = 3'd4;

    // one bit per kind: bit 0 normalize, 1 add, 2 subtract, 3 multiply, 4 divide
    localparam logic [4:0] KM_ALL    = 5'b11111;
    localparam logic [4:0] KM_BIN    = 5'b11110;
    localparam logic [4:0] KM_ADDSUB = 5'b00110;
    localparam logic [4:0] KM_SUB    = 5'b00100;
    localparam logic [4:0] KM_DIV    = 5'b10000;
    localparam logic [4:0] KM_MULDIV = 5'b11000;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_DIV_ZERO = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        UOP_SIGN_L,
        UOP_SIGN_R,
        UOP_NEG_N2,
        UOP_SWAP_R,
        UOP_GCD,
        UOP_DIV,
        UOP_MUL,
        UOP_ADD,
        UOP_CHKBIG
    } uop_t;

    typedef enum logic [2:0] {
        RS_N1,
        RS_D1,
        RS_N2,
        RS_D2,
        RS_T0,
        RS_T1
    } reg_sel_t;

    typedef enum logic [1:0] {
        IT_GCD,
        IT_DIV,
        IT_MUL
    } iter_op_t;

    // sign and magnitude; magnitude exceeds 2^(WORD_BITS-1) only in a result that raises overflow
    typedef struct packed {
        logic  s;
        word_t m;
    } sm_t;

    typedef struct packed {
        uop_t       uop;
        reg_sel_t   a;
        reg_sel_t   b;
        reg_sel_t   dst;
        logic [4:0] kmask;
    } uinst_t;

    typedef struct packed {
        logic     load;
        logic     issue;
        uop_t     uop;
        reg_sel_t a;
        reg_sel_t b;
        reg_sel_t dst;
        logic     publish;
        logic     err;
    } dp_cmd_t;

    typedef struct packed {
        logic l_zden;
        logic l_min;
        logic r_zden;
        logic r_min;
        logic r_nzero;
        logic iter_done;
        logic iter_ovf;
        logic add_ovf;
        logic n1_big;
    } dp_stat_t;

    function automatic uinst_t mk(uop_t u, reg_sel_t a, reg_sel_t b, reg_sel_t d,
                                  logic [4:0] km);
        uinst_t r;
        r.uop   = u;
        r.a     = a;
        r.b     = b;
        r.dst   = d;
        r.kmask = km;
        return r;
    endfunction

    function automatic uinst_t ucode(logic [PC_BITS-1:0] pc);
        uinst_t ui;
        unique case (pc)
            // normalize left operand
            5'd0:  ui = mk(UOP_SIGN_L, RS_N1, RS_D1, RS_N1, KM_ALL);
            5'd1:  ui = mk(UOP_GCD,    RS_N1, RS_D1, RS_T0, KM_ALL);
            5'd2:  ui = mk(UOP_DIV,    RS_N1, RS_T0, RS_N1, KM_ALL);
            5'd3:  ui = mk(UOP_DIV,    RS_D1, RS_T0, RS_D1, KM_ALL);
            // normalize right operand
            5'd4:  ui = mk(UOP_SIGN_R, RS_N2, RS_D2, RS_N2, KM_BIN);
            5'd5:  ui = mk(UOP_GCD,    RS_N2, RS_D2, RS_T0, KM_BIN);
            5'd6:  ui = mk(UOP_DIV,    RS_N2, RS_T0, RS_N2, KM_BIN);
            5'd7:  ui = mk(UOP_DIV,    RS_D2, RS_T0, RS_D2, KM_BIN);
            5'd8:  ui = mk(UOP_NEG_N2, RS_N2, RS_N2, RS_N2, KM_SUB);
            5'd9:  ui = mk(UOP_SWAP_R, RS_N2, RS_D2, RS_N2, KM_DIV);
            // add and subtract over a gcd-scaled common denominator
            5'd10: ui = mk(UOP_GCD,    RS_D1, RS_D2, RS_T0, KM_ADDSUB);
            5'd11: ui = mk(UOP_DIV,    RS_D2, RS_T0, RS_T1, KM_ADDSUB);
            5'd12: ui = mk(UOP_DIV,    RS_D1, RS_T0, RS_T0, KM_ADDSUB);
            5'd13: ui = mk(UOP_MUL,    RS_N1, RS_T1, RS_N1, KM_ADDSUB);
            5'd14: ui = mk(UOP_MUL,    RS_N2, RS_T0, RS_N2, KM_ADDSUB);
            5'd15: ui = mk(UOP_MUL,    RS_D1, RS_T1, RS_D1, KM_ADDSUB);
            5'd16: ui = mk(UOP_ADD,    RS_N1, RS_N2, RS_N1, KM_ADDSUB);
            // multiply and divide with cross cancellation
            5'd17: ui = mk(UOP_GCD,    RS_N1, RS_D2, RS_T0, KM_MULDIV);
            5'd18: ui = mk(UOP_GCD,    RS_N2, RS_D1, RS_T1, KM_MULDIV);
            5'd19: ui = mk(UOP_DIV,    RS_N1, RS_T0, RS_N1, KM_MULDIV);
            5'd20: ui = mk(UOP_DIV,    RS_D2, RS_T0, RS_D2, KM_MULDIV);
            5'd21: ui = mk(UOP_DIV,    RS_N2, RS_T1, RS_N2, KM_MULDIV);
            5'd22: ui = mk(UOP_DIV,    RS_D1, RS_T1, RS_D1, KM_MULDIV);
            5'd23: ui = mk(UOP_MUL,    RS_N1, RS_N2, RS_N1, KM_MULDIV);
            5'd24: ui = mk(UOP_MUL,    RS_D1, RS_D2, RS_D1, KM_MULDIV);
            // final normalize
            5'd25: ui = mk(UOP_CHKBIG, RS_N1, RS_D1, RS_N1, KM_BIN);
            5'd26: ui = mk(UOP_GCD,    RS_N1, RS_D1, RS_T0, KM_BIN);
            5'd27: ui = mk(UOP_DIV,    RS_N1, RS_T0, RS_N1, KM_BIN);
            5'd28: ui = mk(UOP_DIV,    RS_D1, RS_T0, RS_D1, KM_BIN);
            default: ui = mk(UOP_CHKBIG, RS_N1, RS_N1, RS_N1, 5'b00000);
        endcase
        return ui;
    endfunction

endpackage

// ===== hw/rtl/rau_iter.sv =====
`timescale 1ns / 1ps
// Shared multi-cycle unit: binary gcd (one step per cycle), restoring divide
// and shift-add multiply (one bit per cycle). Depends on rau_pkg.
module rau_iter import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  iter_op_t op,
    input  word_t    a,
    input  word_t    b,
    input  logic     neg,
    output logic     done,
    output word_t    res,
    output logic     ovf
);

    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    iter_op_t             op_reg, op_next;
    word_t                x_reg, x_next;
    word_t                y_reg, y_next;
    word_t                r_reg, r_next;
    logic [2*WORD_BITS:0] p_reg, p_next;
    logic [6:0]           k_reg, k_next;
    logic [5:0]           cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;

    logic [WORD_BITS:0]   div_t;
    logic                 div_ge;
    logic [WORD_BITS:0]   mul_sum;
    word_t                lim;

    always_comb
    begin
        div_t   = {r_reg, x_reg[WORD_BITS-1]};
        div_ge  = div_t >= {1'b0, y_reg};
        mul_sum = p_reg[2*WORD_BITS:WORD_BITS]
                  + (p_reg[0] ? {1'b0, y_reg} : {(WORD_BITS+1){1'b0}});
        lim     = WORD_MAX + word_t'(neg_reg);
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        p_next    = p_reg;
        k_next    = k_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            op_next  = op;
            neg_next = neg;
            k_next   = '0;
            cnt_next = '0;
            x_next   = a;
            y_next   = b;
            r_next   = '0;
            if (op == IT_MUL)
            begin
                y_next = a;
                p_next = {{(WORD_BITS+1){1'b0}}, b};
            end
        end
        else if (run_reg)
        begin
            unique case (op_reg)
                IT_GCD:
                begin
                    priority if (x_reg == '0 || y_reg == '0)
                    begin
                        run_next  = 1'b0;
                        done_next = 1'b1;
                    end
                    else if (!x_reg[0] && !y_reg[0])
                    begin
                        x_next = x_reg >> 1;
                        y_next = y_reg >> 1;
                        k_next = k_reg + 7'd1;
                    end
                    else if (!x_reg[0])
                        x_next = x_reg >> 1;
                    else if (!y_reg[0])
                        y_next = y_reg >> 1;
                    else if (x_reg >= y_reg)
                        x_next = (x_reg - y_reg) >> 1;
                    else
                        y_next = (y_reg - x_reg) >> 1;
                end
                IT_DIV:
                begin
                    r_next = div_ge ? WORD_BITS'(div_t - {1'b0, y_reg}) : div_t[WORD_BITS-1:0];
                    x_next = {x_reg[WORD_BITS-2:0], div_ge};
                end
                IT_MUL:
                    p_next = {1'b0, mul_sum, p_reg[WORD_BITS-1:1]};
                default:
                    run_next = 1'b0;
            endcase
            if (op_reg != IT_GCD)
            begin
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(WORD_BITS - 1))
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= IT_GCD;
            cnt_reg  <= '0;
            k_reg    <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
        p_reg   <= p_next;
        neg_reg <= neg_next;
    end

    always_comb
    begin
        unique case (op_reg)
            IT_GCD:  res = (x_reg | y_reg) << k_reg;
            IT_DIV:  res = x_reg;
            default: res = p_reg[WORD_BITS-1:0];
        endcase
        ovf = (op_reg == IT_MUL)
              && ((|p_reg[2*WORD_BITS-1:WORD_BITS]) || (p_reg[WORD_BITS-1:0] > lim));
    end

    assign done = done_reg;

endmodule

// ===== hw/rtl/rau_dp.sv =====
`timescale 1ns / 1ps
// Datapath: sign-magnitude operand registers, adder, output registers and the
// shared iterative unit. Depends on rau_pkg and rau_iter.
module rau_dp import rau_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    input  logic signed [WORD_BITS-1:0] left_numerator,
    input  logic signed [WORD_BITS-1:0] left_denominator,
    input  logic signed [WORD_BITS-1:0] right_numerator,
    input  logic signed [WORD_BITS-1:0] right_denominator,
    output logic signed [WORD_BITS-1:0] result_numerator,
    output logic        [WORD_BITS-2:0] result_denominator
);

    sm_t      n1_reg, n1_next;
    sm_t      d1_reg, d1_next;
    sm_t      n2_reg, n2_next;
    sm_t      d2_reg, d2_next;
    sm_t      t0_reg, t0_next;
    sm_t      t1_reg, t1_next;
    reg_sel_t dst_reg, dst_next;
    logic     sgn_reg, sgn_next;
    word_t    rnum_reg, rnum_next;
    logic [WORD_BITS-2:0] rden_reg, rden_next;

    sm_t                op_a, op_b;
    logic [WORD_BITS+1:0] va, vb, sum;
    sm_t                add_val;
    logic               multi;
    iter_op_t           it_op;
    logic               it_done, it_ovf;
    word_t              it_res;
    logic               wr_en;
    reg_sel_t           wr_sel;
    sm_t                wr_val;

    function automatic sm_t to_sm(word_t x);
        sm_t r;
        r.s = x[WORD_BITS-1];
        r.m = x[WORD_BITS-1] ? (word_t'(0) - x) : x;
        return r;
    endfunction

    function automatic sm_t pick(reg_sel_t sel, sm_t n1, sm_t d1, sm_t n2, sm_t d2,
                                 sm_t t0, sm_t t1);
        sm_t r;
        unique case (sel)
            RS_N1:   r = n1;
            RS_D1:   r = d1;
            RS_N2:   r = n2;
            RS_D2:   r = d2;
            RS_T0:   r = t0;
            default: r = t1;
        endcase
        return r;
    endfunction

    always_comb
    begin
        op_a = pick(cmd.a, n1_reg, d1_reg, n2_reg, d2_reg, t0_reg, t1_reg);
        op_b = pick(cmd.b, n1_reg, d1_reg, n2_reg, d2_reg, t0_reg, t1_reg);
        va   = op_a.s ? ((WORD_BITS+2)'(0) - {2'b00, op_a.m}) : {2'b00, op_a.m};
        vb   = op_b.s ? ((WORD_BITS+2)'(0) - {2'b00, op_b.m}) : {2'b00, op_b.m};
        sum  = va + vb;
        add_val.s = sum[WORD_BITS+1];
        add_val.m = sum[WORD_BITS+1] ? WORD_BITS'((WORD_BITS+2)'(0) - sum)
                                     : sum[WORD_BITS-1:0];
        multi = (cmd.uop == UOP_GCD) || (cmd.uop == UOP_DIV) || (cmd.uop == UOP_MUL);
        unique case (cmd.uop)
            UOP_DIV: it_op = IT_DIV;
            UOP_MUL: it_op = IT_MUL;
            default: it_op = IT_GCD;
        endcase
    end

    rau_iter u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.issue && multi),
        .op    (it_op),
        .a     (op_a.m),
        .b     (op_b.m),
        .neg   (op_a.s ^ op_b.s),
        .done  (it_done),
        .res   (it_res),
        .ovf   (it_ovf)
    );

    always_comb
    begin
        n1_next   = n1_reg;
        d1_next   = d1_reg;
        n2_next   = n2_reg;
        d2_next   = d2_reg;
        t0_next   = t0_reg;
        t1_next   = t1_reg;
        dst_next  = dst_reg;
        sgn_next  = sgn_reg;
        rnum_next = rnum_reg;
        rden_next = rden_reg;
        wr_en     = 1'b0;
        wr_sel    = dst_reg;
        wr_val    = {sgn_reg & (|it_res), it_res};

        if (cmd.load)
        begin
            n1_next = to_sm(left_numerator);
            d1_next = to_sm(left_denominator);
            n2_next = to_sm(right_numerator);
            d2_next = to_sm(right_denominator);
        end
        else if (cmd.issue)
        begin
            unique case (cmd.uop)
                UOP_SIGN_L:
                begin
                    n1_next.s = (n1_reg.s ^ d1_reg.s) & (|n1_reg.m);
                    d1_next.s = 1'b0;
                end
                UOP_SIGN_R:
                begin
                    n2_next.s = (n2_reg.s ^ d2_reg.s) & (|n2_reg.m);
                    d2_next.s = 1'b0;
                end
                UOP_NEG_N2:
                    n2_next.s = !n2_reg.s & (|n2_reg.m);
                UOP_SWAP_R:
                begin
                    n2_next.m = d2_reg.m;
                    d2_next.m = n2_reg.m;
                end
                UOP_ADD:
                begin
                    wr_en  = 1'b1;
                    wr_sel = cmd.dst;
                    wr_val = add_val;
                end
                UOP_GCD, UOP_DIV, UOP_MUL:
                begin
                    dst_next = cmd.dst;
                    // quotient keeps the dividend's sign, product the xor of both
                    sgn_next = (cmd.uop == UOP_DIV) ? op_a.s
                             : (cmd.uop == UOP_MUL) ? (op_a.s ^ op_b.s) : 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        else if (it_done)
            wr_en = 1'b1;

        if (wr_en)
        begin
            unique case (wr_sel)
                RS_N1:   n1_next = wr_val;
                RS_D1:   d1_next = wr_val;
                RS_N2:   n2_next = wr_val;
                RS_D2:   d2_next = wr_val;
                RS_T0:   t0_next = wr_val;
                default: t1_next = wr_val;
            endcase
        end

        if (cmd.publish)
        begin
            rnum_next = cmd.err ? '0 : (n1_reg.s ? (word_t'(0) - n1_reg.m) : n1_reg.m);
            rden_next = cmd.err ? '0 : d1_reg.m[WORD_BITS-2:0];
        end
    end

    always_ff @(posedge clk)
    begin
        n1_reg   <= n1_next;
        d1_reg   <= d1_next;
        n2_reg   <= n2_next;
        d2_reg   <= d2_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        dst_reg  <= dst_next;
        sgn_reg  <= sgn_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
    end

    always_comb
    begin
        stat.l_zden    = (left_denominator == '0);
        stat.l_min     = (left_numerator == WORD_MIN) || (left_denominator == WORD_MIN);
        stat.r_zden    = (right_denominator == '0);
        stat.r_min     = (right_numerator == WORD_MIN) || (right_denominator == WORD_MIN);
        stat.r_nzero   = (right_numerator == '0);
        stat.iter_done = it_done;
        stat.iter_ovf  = it_ovf;
        stat.add_ovf   = (sum[WORD_BITS+1:WORD_BITS-1] != 3'b000)
                         && (sum[WORD_BITS+1:WORD_BITS-1] != 3'b111);
        stat.n1_big    = n1_reg.m[WORD_BITS-1];
    end

    assign result_numerator   = rnum_reg;
    assign result_denominator = rden_reg;

endmodule

// ===== hw/rtl/rau_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: walks the micro-program, decides the status and drives the datapath.
// Depends on rau_pkg.
module rau_ctrl import rau_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] kind,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd,
    output logic       busy,
    output logic       done,
    output logic [1:0] status
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [PC_BITS-1:0]   pc_reg, pc_next;
    logic [2:0]           kind_reg, kind_next;
    status_t              status_reg, status_next;
    logic                 done_reg, done_next;

    uinst_t     ui;
    logic       run;
    logic       last;
    logic       multi;
    logic [2:0] kind_m;

    assign ui     = ucode(pc_reg);
    assign run    = ui.kmask[kind_reg];
    assign last   = (pc_reg == LAST_PC);
    assign multi  = (ui.uop == UOP_GCD) || (ui.uop == UOP_DIV) || (ui.uop == UOP_MUL);
    assign kind_m = (kind > KIND_DIV) ? KIND_NORM : kind;

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        done_next   = 1'b0;
        cmd         = '0;
        cmd.uop     = ui.uop;
        cmd.a       = ui.a;
        cmd.b       = ui.b;
        cmd.dst     = ui.dst;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    pc_next   = '0;
                    kind_next = kind_m;
                    // left operand first, then right, then divide by zero
                    priority if (stat.l_zden)
                        status_next = ST_ZERO_DEN;
                    else if (stat.l_min)
                        status_next = ST_OVERFLOW;
                    else if (kind_m == KIND_NORM)
                        status_next = ST_OK;
                    else if (stat.r_zden)
                        status_next = ST_ZERO_DEN;
                    else if (stat.r_min)
                        status_next = ST_OVERFLOW;
                    else if (kind_m == KIND_DIV && stat.r_nzero)
                        status_next = ST_DIV_ZERO;
                    else
                        status_next = ST_OK;
                    state_next = (status_next != ST_OK) ? S_DONE : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (!run)
                begin
                    if (last)
                        state_next = S_DONE;
                    else
                        pc_next = pc_reg + 1'b1;
                end
                else
                begin
                    cmd.issue = 1'b1;
                    priority if ((ui.uop == UOP_ADD && stat.add_ovf)
                                 || (ui.uop == UOP_CHKBIG && stat.n1_big))
                    begin
                        status_next = ST_OVERFLOW;
                        state_next  = S_DONE;
                    end
                    else if (multi)
                        state_next = S_WAIT;
                    else if (last)
                        state_next = S_DONE;
                    else
                        pc_next = pc_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (stat.iter_done)
                begin
                    priority if (stat.iter_ovf)
                    begin
                        status_next = ST_OVERFLOW;
                        state_next  = S_DONE;
                    end
                    else if (last)
                        state_next = S_DONE;
                    else
                    begin
                        pc_next    = pc_reg + 1'b1;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_DONE:
            begin
                cmd.publish = 1'b1;
                cmd.err     = (status_reg != ST_OK);
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pc_reg     <= '0;
            kind_reg   <= KIND_NORM;
            status_reg <= ST_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> state_reg != S_IDLE)
        else $error("accepted transaction did not leave idle");

    a_done_after_publish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_DONE))
        else $error("result strobe without publish cycle");

    a_iter_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.iter_done |-> state_reg == S_WAIT)
        else $error("iterative unit finished outside wait");

    a_pc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg <= LAST_PC)
        else $error("micro-program counter out of range");

endmodule

// ===== hw/rtl/rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: controller plus datapath.
// Depends on rau_pkg, rau_ctrl, rau_dp (and rau_iter below it).
//
// Raise start with the operands while busy is low; the transaction is taken at that
// edge. One result per transaction comes back on the result ports for exactly one
// cycle with done high, and it cannot be held off, so capture it then. All gcd, divide
// and multiply steps of a transaction pass in turn through one shared iterative unit
// (binary gcd one step per cycle; divide and multiply one bit per cycle), up to 17
// of them for multiply or divide; an input error raises done at the edge after the
// accepting edge.
module rational_arithmetic_unit import rau_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  kind,
    input  logic signed [WORD_BITS-1:0] left_numerator,
    input  logic signed [WORD_BITS-1:0] left_denominator,
    input  logic signed [WORD_BITS-1:0] right_numerator,
    input  logic signed [WORD_BITS-1:0] right_denominator,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] result_numerator,
    output logic        [WORD_BITS-2:0] result_denominator,
    output logic [1:0]                  status
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rau_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .kind   (kind),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    rau_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .stat               (stat),
        .left_numerator     (left_numerator),
        .left_denominator   (left_denominator),
        .right_numerator    (right_numerator),
        .right_denominator  (right_denominator),
        .result_numerator   (result_numerator),
        .result_denominator (result_denominator)
    );

endmodule

// ===== verif/rau_checker.sv =====
`timescale 1ns / 1ps
// Checker for the rational arithmetic unit: predicts each result from the accepted
// operands and compares it with what the unit returns. Depends on rau_pkg.
module rau_checker import rau_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [2:0]                  kind,
    input  logic signed [WORD_BITS-1:0] left_numerator,
    input  logic signed [WORD_BITS-1:0] left_denominator,
    input  logic signed [WORD_BITS-1:0] right_numerator,
    input  logic signed [WORD_BITS-1:0] right_denominator,
    input  logic                        done,
    input  logic signed [WORD_BITS-1:0] result_numerator,
    input  logic        [WORD_BITS-2:0] result_denominator,
    input  logic [1:0]                  status,
    output int                          fail_count,
    output int                          pending,
    output int                          results_seen,
    output int                          errors_seen
);

    typedef struct packed {
        logic signed [WORD_BITS-1:0] num;
        logic        [WORD_BITS-2:0] den;
        status_t                     st;
    } fraction_t;

    fraction_t expected_fractions[$];

    function automatic logic [WORD_BITS-1:0] mag(logic signed [WORD_BITS-1:0] a);
        return a < 0 ? -a : a;
    endfunction

    function automatic logic [WORD_BITS-1:0] gcd_mag(logic [WORD_BITS-1:0] a,
                                                     logic [WORD_BITS-1:0] b);
        logic [WORD_BITS-1:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // divide magnitude by g, keep sign
    function automatic logic signed [WORD_BITS-1:0] scale_down(
        logic signed [WORD_BITS-1:0] a, logic [WORD_BITS-1:0] g);
        logic [WORD_BITS-1:0] q;
        if (g == 0)
            g = 1;
        q = mag(a) / g;
        return a < 0 ? -q : q;
    endfunction

    function automatic bit mul_fits(logic signed [WORD_BITS-1:0] a,
                                    logic signed [WORD_BITS-1:0] b,
                                    output logic signed [WORD_BITS-1:0] r);
        logic signed [2*WORD_BITS-1:0] p;
        p = 128'(a) * 128'(b);
        r = p[WORD_BITS-1:0];
        return p == 128'(r);
    endfunction

    function automatic bit add_fits(logic signed [WORD_BITS-1:0] a,
                                    logic signed [WORD_BITS-1:0] b,
                                    output logic signed [WORD_BITS-1:0] r);
        logic signed [WORD_BITS:0] s;
        s = 65'(a) + 65'(b);
        r = s[WORD_BITS-1:0];
        return s == 65'(r);
    endfunction

    function automatic status_t reduce(logic signed [WORD_BITS-1:0] n,
                                       logic signed [WORD_BITS-1:0] d,
                                       output logic signed [WORD_BITS-1:0] rn,
                                       output logic signed [WORD_BITS-1:0] rd);
        logic [WORD_BITS-1:0] g;
        rn = 0;
        rd = 0;
        if (d == 0)
            return ST_ZERO_DEN;
        if (n == WORD_MIN || d == WORD_MIN)
            return ST_OVERFLOW;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        g = gcd_mag(mag(n), mag(d));
        rn = scale_down(n, g);
        rd = scale_down(d, g);
        return ST_OK;
    endfunction

    function automatic status_t sum_fraction(logic signed [WORD_BITS-1:0] n1, d1, n2, d2,
                                             output logic signed [WORD_BITS-1:0] rn, rd);
        logic [WORD_BITS-1:0] common;
        logic signed [WORD_BITS-1:0] ls, rs, a, b, d, s;
        rn = 0;
        rd = 0;
        common = gcd_mag(mag(d1), mag(d2));
        ls = scale_down(d2, common);
        rs = scale_down(d1, common);
        if (!mul_fits(n1, ls, a) || !mul_fits(n2, rs, b) || !mul_fits(d1, ls, d)
            || !add_fits(a, b, s))
            return ST_OVERFLOW;
        return reduce(s, d, rn, rd);
    endfunction

    function automatic status_t product_fraction(logic signed [WORD_BITS-1:0] n1, d1, n2, d2,
                                                 output logic signed [WORD_BITS-1:0] rn, rd);
        logic [WORD_BITS-1:0] cl, cr;
        logic signed [WORD_BITS-1:0] pn, pd;
        rn = 0;
        rd = 0;
        cl = gcd_mag(mag(n1), mag(d2));
        cr = gcd_mag(mag(n2), mag(d1));
        if (!mul_fits(scale_down(n1, cl), scale_down(n2, cr), pn)
            || !mul_fits(scale_down(d1, cr), scale_down(d2, cl), pd))
            return ST_OVERFLOW;
        return reduce(pn, pd, rn, rd);
    endfunction

    function automatic fraction_t predict_fraction(logic [2:0] k,
                                                   logic signed [WORD_BITS-1:0] ln, ld, rnum, rden);
        logic signed [WORD_BITS-1:0] n1, d1, n2, d2, on, od, in2, id2;
        status_t st;
        fraction_t f;
        on = 0;
        od = 0;
        st = reduce(ln, ld, n1, d1);
        if (k > KIND_DIV)
            k = KIND_NORM;
        if (st == ST_OK && k == KIND_NORM)
        begin
            on = n1;
            od = d1;
        end
        else if (st == ST_OK)
        begin
            st = reduce(rnum, rden, n2, d2);
            if (st == ST_OK)
            begin
                case (k)
                    KIND_ADD: st = sum_fraction(n1, d1, n2, d2, on, od);
                    KIND_SUB: st = sum_fraction(n1, d1, -n2, d2, on, od);
                    KIND_MUL: st = product_fraction(n1, d1, n2, d2, on, od);
                    default:
                    begin
                        if (n2 == 0)
                            st = ST_DIV_ZERO;
                        else
                        begin
                            st = reduce(d2, n2, in2, id2);
                            if (st == ST_OK)
                                st = product_fraction(n1, d1, in2, id2, on, od);
                        end
                    end
                endcase
            end
        end
        if (st != ST_OK)
        begin
            on = 0;
            od = 0;
        end
        f.num = on;
        f.den = od[WORD_BITS-2:0];
        f.st = st;
        return f;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fraction_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
            errors_seen <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (status != ST_OK)
                    errors_seen <= errors_seen + 1;
                if (expected_fractions.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: result with no transaction pending: %0d/%0d st %0d",
                                 result_numerator, result_denominator, status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_fractions.pop_front();
                    if (e.num !== result_numerator || e.den !== result_denominator
                        || e.st !== status)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                                     e.num, e.den, e.st, result_numerator,
                                     result_denominator, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            // push after the pop so a same-edge result matches the older entry
            if (start && !busy)
                expected_fractions.push_back(predict_fraction(kind, left_numerator,
                    left_denominator, right_numerator, right_denominator));
            pending <= expected_fractions.size();
        end
    end

endmodule

// ===== verif/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the rational arithmetic unit: clock, reset, operand stimulus
// and verdict. Depends on rau_pkg, rational_arithmetic_unit and rau_checker.
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1500;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] kind;
    logic signed [WORD_BITS-1:0] left_numerator, left_denominator;
    logic signed [WORD_BITS-1:0] right_numerator, right_denominator;
    logic done;
    logic signed [WORD_BITS-1:0] result_numerator;
    logic [WORD_BITS-2:0] result_denominator;
    logic [1:0] status;
    int fail_count, pending, results_seen, errors_seen;
    int sent;
    int idle_cycles = 0;
    bit timed_out;

    rational_arithmetic_unit dut (.*);

    rau_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // count cycles in which nothing is accepted and no result returns
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    function automatic logic signed [WORD_BITS-1:0] rand_word();
        logic signed [WORD_BITS-1:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(9))
            0: w = WORD_MIN;
            1: w = WORD_MAX;
            2: w = 0;
            3, 4: w = $signed(WORD_BITS'($urandom_range(200))) - 100;
            5, 6: w = $signed(WORD_BITS'($urandom_range(2000000)))
                      * ($urandom_range(1) ? 1 : -1);
            7: w = w >>> $urandom_range(62);
            default: ;
        endcase
        return w;
    endfunction

    task automatic send(input logic [2:0] k, input logic signed [WORD_BITS-1:0] ln, ld,
                        rn, rd);
        int gap;
        gap = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(2);
        if ($urandom_range(3) == 0)
            gap = 0;
        // step off the edge where start was last dropped
        repeat (gap + 1) @(negedge clk);
        start <= 1'b1;
        kind <= k;
        left_numerator <= ln;
        left_denominator <= ld;
        right_numerator <= rn;
        right_denominator <= rd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [2:0] k;
        logic signed [WORD_BITS-1:0] a, b;
        rst_n = 0;
        start = 0;
        kind = 0;
        left_numerator = 0;
        left_denominator = 0;
        right_numerator = 0;
        right_denominator = 0;
        sent = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed corners
        send(KIND_NORM, 6, -4, 0, 0);
        send(KIND_NORM, 0, -7, 1, 1);
        send(KIND_NORM, 5, 0, 1, 1);
        send(KIND_NORM, WORD_MIN, 1, 1, 1);
        send(KIND_NORM, 1, WORD_MIN, 1, 1);
        send(KIND_NORM, WORD_MIN, 0, 1, 1);
        send(KIND_ADD, 1, 2, 1, 3);
        send(KIND_SUB, 1, 2, 1, 2);
        send(KIND_MUL, -2, 3, 9, -4);
        send(KIND_DIV, 3, 4, 0, 5);
        send(KIND_DIV, 3, 4, 5, 0);
        send(KIND_DIV, 3, 4, WORD_MIN, 7);
        send(KIND_ADD, WORD_MAX, 1, 1, 1);
        send(KIND_SUB, WORD_MIN + 1, 1, 1, 1);
        send(KIND_MUL, WORD_MAX, 1, 2, 1);
        send(KIND_DIV, WORD_MAX, 1, 1, WORD_MAX);
        send(KIND_ADD, 1, WORD_MAX, 1, WORD_MAX - 1);
        send(3'd5, 10, 4, 0, 0);
        send(3'd6, -3, -9, 0, 0);
        send(3'd7, WORD_MAX, WORD_MAX, 0, 0);
        send(KIND_ADD, 3, 0, 1, 1);
        send(KIND_ADD, 1, 1, 3, 0);
        drain();
        // every result is back at this point; add a random pause before the random items
        repeat ($urandom_range(20)) @(negedge clk);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            k = $urandom_range(9) == 0 ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            a = rand_word();
            b = rand_word();
            if ($urandom_range(7) == 0)
                send(k, a, b, rand_word(), rand_word());
            else
                send(k, a, b, $signed(64'($urandom_range(5000))) - 2500,
                     $signed(64'($urandom_range(5000))) - 2500);
            if (i % 500 == 250)
                drain();
        end

        drain();
        repeat (20) @(negedge clk);
        $display("Sent %0d transactions; %0d results checked, %0d with error status.",
                 sent, results_seen, errors_seen);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
